// File: rtl/core/pcfs_pkg.sv
package pcfs_pkg;

  localparam int SOURCES_DEF = 8;

  localparam logic [15:0] COULOMB_K = 16'd45000;

  // Per-term magnitude cap, 2^40
  localparam logic [40:0] TERM_CAP = {1'b1, 40'd0};

  localparam logic signed [47:0] SUM_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = -48'sh0000_8000_0000;

  localparam logic [0:0] OP_LOAD  = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  localparam logic [0:0] REG_SOURCES_IN_USE = 1'b0;

  typedef struct packed {
    logic              op;
    logic [2:0]        slot;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] charge_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic              singular;
    logic              saturated;
  } out_t;

endpackage

// File: rtl/core/pcfs_div.sv
module pcfs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [46:0] num,
  input  logic [57:0] den,
  output logic        done,
  output logic [40:0] mag,
  output logic        clip
);

  localparam logic [40:0] TERM_CAP_L = pcfs_pkg::TERM_CAP;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [57:0] rem_r;
  logic [40:0] sh_r;
  logic [40:0] quo_r;
  logic        ovf_r;
  logic [57:0] den_r;
  logic [58:0] trial;
  logic        fits;

  assign trial = {rem_r, sh_r[40]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= 6'd40;
      // quotient of 2^41 or more is clipped anyway
      ovf_r <= {20'd0, num} >= {den, 9'd0};
      rem_r <= {20'd0, num[46:9]};
      sh_r  <= {num[8:0], 32'd0};
      quo_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      sh_r  <= {sh_r[39:0], 1'b0};
      quo_r <= {quo_r[39:0], fits};
      rem_r <= fits ? 58'(trial - {1'b0, den_r}) : trial[57:0];
    end
  end

  assign done = done_r;
  assign clip = ovf_r || (quo_r > TERM_CAP_L);
  assign mag  = clip ? TERM_CAP_L : quo_r;

endmodule

// File: rtl/core/point_charge_field_sum_unit.sv
// Load items produce no result.
// A query visits each of the active sources in turn: each takes a 25-step root, a wait
// on the two parallel 41-step divides and 12 further states; a source at the query point
// skips the root and the divides.
// The result waits in an output register; the next item can be taken in the same cycle that it becomes valid.
// Reset clears control state and sources_in_use; the charge table is not cleared.
module point_charge_field_sum_unit #(
  parameter int SOURCES = pcfs_pkg::SOURCES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pcfs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pcfs_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IDXW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CW0  = $clog2(SOURCES + 1);
  localparam int CW   = (CW0 > 4) ? CW0 : 4;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_SQX  = 4'd3;
  localparam logic [3:0] ST_SQY  = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_DEN0 = 4'd7;
  localparam logic [3:0] ST_DEN1 = 4'd8;
  localparam logic [3:0] ST_NUMX = 4'd9;
  localparam logic [3:0] ST_NUMY = 4'd10;
  localparam logic [3:0] ST_DIV  = 4'd11;
  localparam logic [3:0] ST_DWT  = 4'd12;
  localparam logic [3:0] ST_ACC  = 4'd13;
  localparam logic [3:0] ST_NEXT = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  siu_r;
  logic [CW-1:0] n_r, lim_r, lim_nxt;

  logic [47:0] mem [SOURCES];
  logic [47:0] rd_r;

  logic signed [15:0] px_r, py_r;
  logic [15:0] adx_r, ady_r, aq_r;
  logic        negx_r, negy_r;
  logic [31:0] sq_r;
  logic [32:0] r2_r;
  logic [49:0] sqv_r, sqres_r, sqbit_r;
  logic [4:0]  scnt_r;
  logic [41:0] den_lo_r;
  logic [57:0] den_r;
  logic [30:0] kq_r;
  logic [46:0] numx_r, numy_r;
  logic signed [47:0] accx_r, accy_r;
  logic        sing_r, clip_r;

  logic        out_valid_r;
  pcfs_pkg::out_t out_r;

  logic signed [16:0] dx, dy;
  logic signed [15:0] sx, sy, sq_q;
  logic [49:0] sq_try;
  logic        div_start, divx_done, divy_done, clipx, clipy;
  logic [40:0] magx, magy;
  logic signed [47:0] termx, termy;
  logic        in_acc, out_acc, wr_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign wr_acc  = psel && penable && pwrite && pready;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == pcfs_pkg::REG_SOURCES_IN_USE) ? {28'd0, siu_r} : 32'd0;

  assign sx   = rd_r[47:32];
  assign sy   = rd_r[31:16];
  assign sq_q = rd_r[15:0];
  assign dx   = {px_r[15], px_r} - {sx[15], sx};
  assign dy   = {py_r[15], py_r} - {sy[15], sy};
  assign sq_try = sqres_r + sqbit_r;
  assign div_start = (state_r == ST_DIV);

  always_comb begin
    lim_nxt = CW'(siu_r);
    if (CW'(siu_r) > CW'(SOURCES)) lim_nxt = CW'(SOURCES);
  end

  assign termx = negx_r ? 48'(signed'({7'd0, magx})) : -48'(signed'({7'd0, magx}));
  assign termy = negy_r ? 48'(signed'({7'd0, magy})) : -48'(signed'({7'd0, magy}));

  pcfs_div u_divx (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numx_r), .den(den_r),
    .done(divx_done), .mag(magx), .clip(clipx)
  );

  pcfs_div u_divy (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numy_r), .den(den_r),
    .done(divy_done), .mag(magy), .clip(clipy)
  );

  // Charge table
  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == pcfs_pkg::OP_LOAD && int'(in_data.slot) < SOURCES) begin
      mem[IDXW'(in_data.slot)] <= {in_data.point_x, in_data.point_y, in_data.charge_value};
    end
    rd_r <= mem[n_r[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= 4'd0;
    end else if (wr_acc && paddr[2] == pcfs_pkg::REG_SOURCES_IN_USE) begin
      siu_r <= pwdata[3:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_data.op == pcfs_pkg::OP_QUERY) begin
        state_nxt = (lim_nxt == '0) ? ST_DONE : ST_RD;
      end
      ST_RD:   state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (r2_r == '0) ? ST_NEXT : ST_SQRT;
      ST_SQRT: if (scnt_r == 5'd0) state_nxt = ST_DEN0;
      ST_DEN0: state_nxt = ST_DEN1;
      ST_DEN1: state_nxt = ST_NUMX;
      ST_NUMX: state_nxt = ST_NUMY;
      ST_NUMY: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_DWT;
      ST_DWT:  if (divx_done && divy_done) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = (n_r + CW'(1) == lim_r) ? ST_DONE : ST_RD;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r   <= in_data.point_x;
        py_r   <= in_data.point_y;
        n_r    <= '0;
        lim_r  <= lim_nxt;
        accx_r <= '0;
        accy_r <= '0;
        sing_r <= 1'b0;
        clip_r <= 1'b0;
      end
      ST_DIFF: begin
        adx_r  <= dx[16] ? 16'(-dx) : dx[15:0];
        ady_r  <= dy[16] ? 16'(-dy) : dy[15:0];
        aq_r   <= sq_q[15] ? 16'(-sq_q) : sq_q;
        // field is minus q*d/r^3
        negx_r <= sq_q[15] != dx[16];
        negy_r <= sq_q[15] != dy[16];
      end
      ST_SQX: sq_r <= adx_r * adx_r;
      ST_SQY: r2_r <= {1'b0, sq_r} + {1'b0, 32'(ady_r * ady_r)};
      ST_CHK: begin
        if (r2_r == '0) sing_r <= 1'b1;
        sqv_r   <= {r2_r, 16'd0} & {50{1'b1}};
        sqres_r <= '0;
        sqbit_r <= {2'b01, 48'd0};
        scnt_r  <= 5'd24;
        kq_r    <= 31'(pcfs_pkg::COULOMB_K * aq_r);
      end
      ST_SQRT: begin
        if (sqv_r >= sq_try) begin
          sqv_r   <= sqv_r - sq_try;
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
        scnt_r  <= scnt_r - 5'd1;
      end
      ST_DEN0: den_lo_r <= r2_r[16:0] * sqres_r[24:0];
      ST_DEN1: den_r <= 58'(den_lo_r) + {41'(r2_r[32:17] * sqres_r[24:0]), 17'd0};
      ST_NUMX: numx_r <= kq_r * adx_r;
      ST_NUMY: numy_r <= kq_r * ady_r;
      ST_ACC: begin
        accx_r <= accx_r + termx;
        accy_r <= accy_r + termy;
        if (clipx || clipy) clip_r <= 1'b1;
      end
      ST_NEXT: n_r <= n_r + CW'(1);
      ST_DONE: if (!out_valid_r || !out_stall) begin
        out_r.field_x   <= (accx_r > pcfs_pkg::SUM_MAX) ? 32'h7FFF_FFFF :
                           (accx_r < pcfs_pkg::SUM_MIN) ? 32'h8000_0000 : accx_r[31:0];
        out_r.field_y   <= (accy_r > pcfs_pkg::SUM_MAX) ? 32'h7FFF_FFFF :
                           (accy_r < pcfs_pkg::SUM_MIN) ? 32'h8000_0000 : accy_r[31:0];
        out_r.singular  <= sing_r;
        out_r.saturated <= clip_r ||
                           accx_r > pcfs_pkg::SUM_MAX || accx_r < pcfs_pkg::SUM_MIN ||
                           accy_r > pcfs_pkg::SUM_MAX || accy_r < pcfs_pkg::SUM_MIN;
      end
      default: ;
    endcase
  end

endmodule
